// File: rtl/ssq_pkg.sv
// ----------------------------------------------------------------------------
// ssq_pkg: shared types and constants of the scan sweep sequencer
// Phase codes, actions, motor ops, events, controller state, command bundle.
// ----------------------------------------------------------------------------
package ssq_pkg;

    localparam int SETTLE_MS        = 500;
    localparam int STEP_SETTLE_MS   = 100;
    localparam int UNWRAP_MAX_STEPS = 6400;

    typedef enum logic [3:0] {
        PH_IDLE, PH_HOMING, PH_PARKING, PH_SETTLING, PH_SWEEPING, PH_DONE,
        PH_UNWRAP, PH_STEP_MOVE, PH_STEP_SETTLE, PH_STEP_CAPTURE
    } t_phase;

    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_START  = 3'd1;
    localparam logic [2:0] ACT_ABORT  = 3'd2;
    localparam logic [2:0] ACT_UNWRAP = 3'd3;
    localparam logic [2:0] ACT_HOME   = 3'd4;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_ABS  = 2'd1;
    localparam logic [1:0] OP_REL  = 2'd2;
    localparam logic [1:0] OP_STOP = 2'd3;

    localparam logic [1:0] SPD_TRAVEL = 2'd0;
    localparam logic [1:0] SPD_HOMING = 2'd1;
    localparam logic [1:0] SPD_STEP   = 2'd2;
    localparam logic [1:0] SPD_SWEEP  = 2'd3;

    localparam logic [3:0] EV_NONE     = 4'd0;
    localparam logic [3:0] EV_BUSY     = 4'd1;
    localparam logic [3:0] EV_REJECT   = 4'd2;
    localparam logic [3:0] EV_HOMED    = 4'd3;
    localparam logic [3:0] EV_START    = 4'd4;
    localparam logic [3:0] EV_COMPLETE = 4'd5;
    localparam logic [3:0] EV_IDLE     = 4'd6;
    localparam logic [3:0] EV_ABORTED  = 4'd7;
    localparam logic [3:0] EV_UNWRAP   = 4'd8;
    localparam logic [3:0] EV_HOMESET  = 4'd9;

    localparam logic [2:0] REG_HALF   = 3'd0;
    localparam logic [2:0] REG_BACK   = 3'd1;
    localparam logic [2:0] REG_TRAVEL = 3'd2;
    localparam logic [2:0] REG_CYCLE  = 3'd3;
    localparam logic [2:0] REG_MODE   = 3'd4;
    localparam logic [2:0] REG_STOPS  = 3'd5;
    localparam logic [2:0] REG_DWELL  = 3'd6;
    localparam logic [2:0] REG_RATE   = 3'd7;

    // Target source selected by the controller
    localparam logic [2:0] TGT_ZERO    = 3'd0;
    localparam logic [2:0] TGT_TRAVEL  = 3'd1; // -home travel
    localparam logic [2:0] TGT_UNWRAP  = 3'd2;
    localparam logic [2:0] TGT_PARK    = 3'd3; // -H
    localparam logic [2:0] TGT_SWEEP   = 3'd4; // +H
    localparam logic [2:0] TGT_STOP    = 3'd5; // divider quotient

    localparam int DIV_W = 48;

    typedef enum logic [2:0] {
        CS_IDLE, CS_DIV, CS_HOME_FIX, CS_OUT, CS_HOLD
    } t_ctl;

    typedef struct packed {
        logic       div_start;   // launch a division
        logic       div_home;    // 1 homing renumber, 0 stop position
        logic [1:0] op;
        logic [2:0] tgt_sel;
        logic [1:0] speed;
        logic       ramp;
        logic       load;
        logic       load_home;   // value from the renumber, else zero
        logic       result_we;   // capture the output word
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_sts;

endpackage

// File: rtl/ssq_if.sv
// ----------------------------------------------------------------------------
// ssq_if: valid/ready channel carrying one payload word
// Generic over the payload type.
// ----------------------------------------------------------------------------
interface ssq_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ssq_types.sv
// ----------------------------------------------------------------------------
// ssq_types: payload structs of the channels
// Input word, result word, configuration write.
// ----------------------------------------------------------------------------
package ssq_types;
    typedef struct packed {
        logic [2:0]         action;
        logic               motor_running;
        logic signed [31:0] motor_position;
        logic signed [23:0] unwrap_steps;
    } t_in;

    typedef struct packed {
        logic [3:0]         scan_state;
        logic [1:0]         motor_op;
        logic signed [31:0] motor_target;
        logic [1:0]         speed_select;
        logic               ramp_enable;
        logic               position_load;
        logic signed [31:0] position_value;
        logic [3:0]         event_code;
        logic [11:0]        stop_index;
    } t_out;

    typedef struct packed {
        logic [2:0]  index;
        logic [23:0] wdata;
    } t_cfg;
endpackage

// File: rtl/ssq_datapath.sv
// ----------------------------------------------------------------------------
// ssq_datapath: configuration, divider and result assembly
// Serial restoring divider for homing renumber and stop positions.
// ----------------------------------------------------------------------------
module ssq_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_index,
    input  logic [23:0]                i_cfg_wdata,
    input  ssq_pkg::t_cmd              i_cmd,
    input  logic signed [31:0]         i_pos,
    input  logic signed [23:0]         i_unw,
    input  logic [11:0]                i_stop_idx,
    input  logic [3:0]                 i_state,
    input  logic [3:0]                 i_event,
    output ssq_pkg::t_sts              o_sts,
    output logic                       o_mode,
    output logic [11:0]                o_stop_count,
    output logic [15:0]                o_dwell,
    output ssq_types::t_out            o_result
);
    import ssq_pkg::*;
    import ssq_types::*;

    logic [15:0] r_half, r_back, r_cycle, r_dwell;
    logic [23:0] r_travel, r_rate;
    logic        r_mode;
    logic [11:0] r_stops;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 16'd1600; r_back <= 16'd160; r_travel <= 24'd4000;
            r_cycle <= 16'd64; r_mode <= 1'b0; r_stops <= 12'd100;
            r_dwell <= 16'd200; r_rate <= 24'd25600;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HALF:   r_half   <= i_cfg_wdata[15:0];
                REG_BACK:   r_back   <= i_cfg_wdata[15:0];
                REG_TRAVEL: r_travel <= i_cfg_wdata;
                REG_CYCLE:  r_cycle  <= i_cfg_wdata[15:0];
                REG_MODE:   r_mode   <= i_cfg_wdata[0];
                REG_STOPS:  r_stops  <= i_cfg_wdata[11:0];
                REG_DWELL:  r_dwell  <= i_cfg_wdata[15:0];
                REG_RATE:   r_rate   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_mode       = r_mode;
    assign o_stop_count = r_stops;
    assign o_dwell      = r_dwell;

    // Unsigned division of a magnitude, one quotient bit per cycle.
    // Homing: mag = |want - pos|, d = cycle.
    // Stop: mag = |2*H*(2i-N)| + N, d = 2N.
    logic [DIV_W-1:0] r_rem, r_quo, r_den;
    logic [5:0]       r_cnt;
    logic             r_busy, r_neg, r_home;
    logic signed [33:0] r_base;   // pos for homing
    logic signed [33:0] r_want;

    logic signed [33:0] want_w, diff_w;
    logic signed [13:0] twoi_n;
    logic signed [30:0] num_w;      // H*(2i-N)
    logic [DIV_W-1:0]   mag_w, den_w;
    logic [15:0]        cyc_w;
    logic [DIV_W:0]     trial;

    always_comb begin
        cyc_w  = (r_cycle == 16'd0) ? 16'd1 : r_cycle;
        want_w = -$signed({18'd0, r_half}) - $signed({18'd0, r_back});
        diff_w = want_w - 34'(i_pos);
        twoi_n = $signed({1'b0, i_stop_idx, 1'b0}) - $signed({2'b0, r_stops});
        num_w  = 31'($signed({1'b0, r_half}) * twoi_n);
        if (i_cmd.div_home) begin
            mag_w = diff_w[33] ? DIV_W'(-diff_w) : DIV_W'(diff_w);
            den_w = DIV_W'(cyc_w);
        end else begin
            mag_w = num_w[30] ? DIV_W'({-num_w, 1'b0}) : DIV_W'({num_w, 1'b0});
            mag_w = mag_w + DIV_W'(r_stops);
            den_w = DIV_W'({r_stops, 1'b0});
        end
        trial = {r_rem[DIV_W-1:0], r_quo[DIV_W-1]} - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_quo  <= mag_w;
            r_den  <= den_w;
            r_home <= i_cmd.div_home;
            r_neg  <= i_cmd.div_home ? diff_w[33] : num_w[30];
            r_base <= 34'(i_pos);
            r_want <= want_w;
        end else if (r_busy) begin
            if (!trial[DIV_W]) begin
                r_rem <= trial[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DIV_W-2:0], r_quo[DIV_W-1]};
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_sts.div_busy = r_busy;

    // Homing: k truncated toward zero, then one down when above want.
    // k*cycle equals sign*q*cycle; the value is want - sign*rem - adjust.
    logic signed [33:0] home_v, stop_v;
    logic signed [33:0] rem_s;
    always_comb begin
        rem_s = 34'(r_rem);
        // pos + k*c = want - (diff - k*c); diff - k*c = sign*rem
        home_v = r_neg ? (r_want + rem_s) : (r_want - rem_s);
        if (r_neg && r_rem != '0)
            home_v = home_v - 34'(cyc_w);
        stop_v = r_neg ? -34'(r_quo) : 34'(r_quo);
        if (r_stops == 12'd0)
            stop_v = -$signed({18'd0, r_half});
    end

    logic signed [31:0] tgt;
    always_comb begin
        case (i_cmd.tgt_sel)
            TGT_TRAVEL: tgt = -$signed({8'd0, r_travel});
            TGT_UNWRAP: tgt = 32'(i_unw);
            TGT_PARK:   tgt = -$signed({16'd0, r_half});
            TGT_SWEEP:  tgt = $signed({16'd0, r_half});
            TGT_STOP:   tgt = stop_v[31:0];
            default:    tgt = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result_we) begin
            o_result.scan_state     <= i_state;
            o_result.motor_op       <= i_cmd.op;
            o_result.motor_target   <= tgt;
            o_result.speed_select   <= i_cmd.speed;
            o_result.ramp_enable    <= i_cmd.ramp;
            o_result.position_load  <= i_cmd.load;
            o_result.position_value <= i_cmd.load_home ? home_v[31:0] : 32'd0;
            o_result.event_code     <= i_event;
            o_result.stop_index     <= i_stop_idx;
        end
    end

    logic unused;
    assign unused = ^{r_rate, r_home, r_base};
endmodule

// File: rtl/ssq_control.sv
// ----------------------------------------------------------------------------
// ssq_control: phase machine and item handshake
// Decodes each word, launches divisions and commands the result capture.
// ----------------------------------------------------------------------------
module ssq_control (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [2:0]           i_action,
    input  logic                 i_running,
    input  logic signed [23:0]   i_unw,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_mode,
    input  logic [11:0]          i_stop_count,
    input  logic [15:0]          i_dwell,
    input  ssq_pkg::t_sts        i_sts,
    output ssq_pkg::t_cmd        o_cmd,
    output logic [11:0]          o_stop_idx,
    output logic [3:0]           o_state,
    output logic [3:0]           o_event
);
    import ssq_pkg::*;

    t_ctl   r_cs, n_cs;
    t_phase r_phase, n_phase;
    logic [15:0] r_timer, n_timer;
    logic [11:0] r_stop, n_stop;
    logic        r_mode, n_mode;
    logic [2:0]  r_act;
    logic        r_run;
    logic signed [23:0] r_unw;
    logic        r_home;       // pending division is a renumber

    logic accept;
    assign accept = i_in_valid && o_in_ready;

    // Next state
    always_comb begin
        n_cs = r_cs;
        case (r_cs)
            CS_IDLE:     if (accept) n_cs = CS_OUT;
            CS_OUT:      n_cs = o_cmd.div_start ? CS_DIV : CS_HOLD;
            CS_DIV:      if (!i_sts.div_busy) n_cs = CS_HOME_FIX;
            CS_HOME_FIX: n_cs = CS_HOLD;
            CS_HOLD:     if (i_out_ready) n_cs = CS_IDLE;
            default:     n_cs = CS_IDLE;
        endcase
    end

    // Phase logic, evaluated in CS_OUT on the stored word
    logic [15:0] t1;
    logic        at_rest, bad_unw;
    always_comb begin
        n_phase = r_phase; n_timer = r_timer; n_stop = r_stop; n_mode = r_mode;
        o_cmd   = '0;
        o_event = EV_NONE;
        t1      = (r_timer == 16'hFFFF) ? r_timer : r_timer + 16'd1;
        at_rest = (r_phase == PH_IDLE) || (r_phase == PH_DONE);
        bad_unw = (r_unw == 24'sd0) || (r_unw > 24'(UNWRAP_MAX_STEPS))
                  || (r_unw < -24'(UNWRAP_MAX_STEPS));
        case (r_cs)
            CS_OUT: begin
                o_cmd.result_we = 1'b1;
                case (r_act)
                    ACT_TICK: begin
                        n_timer = t1;
                        case (r_phase)
                            PH_HOMING: if (!r_run) begin
                                o_cmd = '{div_start: 1'b1, div_home: 1'b1, op: OP_ABS,
                                          tgt_sel: TGT_PARK, speed: SPD_TRAVEL,
                                          ramp: 1'b1, load: 1'b1, load_home: 1'b1,
                                          result_we: 1'b0};
                                n_phase = PH_PARKING; n_timer = '0; o_event = EV_HOMED;
                            end
                            PH_PARKING: if (!r_run) begin
                                n_phase = PH_SETTLING; n_timer = '0;
                            end
                            PH_SETTLING: if (t1 >= 16'(SETTLE_MS)) begin
                                if (r_mode) n_phase = PH_STEP_CAPTURE;
                                else begin
                                    o_cmd.op = OP_ABS; o_cmd.tgt_sel = TGT_SWEEP;
                                    o_cmd.speed = SPD_SWEEP;
                                    n_phase = PH_SWEEPING;
                                end
                                n_timer = '0; o_event = EV_START;
                            end
                            PH_SWEEPING: if (!r_run) begin
                                n_phase = PH_DONE; n_timer = '0; o_event = EV_COMPLETE;
                            end
                            PH_DONE: if (!r_run) begin
                                n_phase = PH_IDLE; n_timer = '0; o_event = EV_IDLE;
                            end
                            PH_UNWRAP: if (!r_run) begin
                                o_cmd.load = 1'b1;
                                n_phase = PH_IDLE; n_timer = '0; o_event = EV_UNWRAP;
                            end
                            PH_STEP_MOVE: if (!r_run) begin
                                n_phase = PH_STEP_SETTLE; n_timer = '0;
                            end
                            PH_STEP_SETTLE: if (t1 >= 16'(STEP_SETTLE_MS)) begin
                                n_phase = PH_STEP_CAPTURE; n_timer = '0;
                            end
                            PH_STEP_CAPTURE: if (t1 >= i_dwell) begin
                                n_timer = '0;
                                if (r_stop >= i_stop_count) begin
                                    n_phase = PH_DONE; o_event = EV_COMPLETE;
                                end else begin
                                    n_stop = r_stop + 12'd1;
                                    o_cmd = '{div_start: 1'b1, div_home: 1'b0,
                                              op: OP_ABS, tgt_sel: TGT_STOP,
                                              speed: SPD_STEP, ramp: 1'b0, load: 1'b0,
                                              load_home: 1'b0, result_we: 1'b0};
                                    n_phase = PH_STEP_MOVE;
                                end
                            end
                            default: ;
                        endcase
                    end
                    ACT_START: begin
                        if (!at_rest) o_event = EV_BUSY;
                        else begin
                            n_mode = i_mode; n_stop = '0;
                            o_cmd.op = OP_REL; o_cmd.tgt_sel = TGT_TRAVEL;
                            o_cmd.speed = SPD_HOMING; o_cmd.ramp = 1'b1;
                            n_phase = PH_HOMING; n_timer = '0;
                        end
                    end
                    ACT_ABORT: begin
                        o_cmd.op = OP_STOP;
                        n_phase = PH_IDLE; n_timer = '0; o_event = EV_ABORTED;
                    end
                    ACT_UNWRAP: begin
                        if (!at_rest) o_event = EV_BUSY;
                        else if (bad_unw) o_event = EV_REJECT;
                        else begin
                            o_cmd.op = OP_REL; o_cmd.tgt_sel = TGT_UNWRAP;
                            o_cmd.ramp = 1'b1;
                            n_phase = PH_UNWRAP; n_timer = '0;
                        end
                    end
                    ACT_HOME: begin
                        o_cmd.load = 1'b1; o_event = EV_HOMESET;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Held command and event of CS_OUT, kept for the replay copy below
    t_cmd        r_cmd;
    logic [3:0]  r_event;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs <= CS_IDLE; r_phase <= PH_IDLE; r_timer <= '0;
            r_stop <= '0; r_mode <= 1'b0;
        end else begin
            r_cs <= n_cs;
            if (r_cs == CS_OUT) begin
                r_phase <= n_phase; r_timer <= n_timer;
                r_stop <= n_stop; r_mode <= n_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act <= i_action; r_run <= i_running; r_unw <= i_unw;
        end
        if (r_cs == CS_OUT) begin
            r_cmd <= o_cmd; r_event <= o_event; r_home <= o_cmd.div_home;
        end
    end

    // Replay copy of the held command with capture on; read only by the unused tap
    t_cmd cmd_out;
    always_comb begin
        cmd_out = r_cmd;
        cmd_out.div_start = 1'b0;
        cmd_out.div_home  = r_home;
        cmd_out.result_we = 1'b1;
    end

    assign o_in_ready  = (r_cs == CS_IDLE);
    assign o_out_valid = (r_cs == CS_HOLD);
    assign o_stop_idx  = (r_cs == CS_OUT) ? n_stop : r_stop;
    assign o_state     = (r_cs == CS_OUT) ? 4'(n_phase) : 4'(r_phase);

    // Copies of the live decode and of the event replay in CS_HOME_FIX, read only by the unused tap
    t_cmd  cmd_live;
    assign cmd_live = o_cmd;
    logic [3:0] ev_sel;
    assign ev_sel = (r_cs == CS_HOME_FIX) ? r_event : o_event;
    logic unused;
    assign unused = ^{cmd_live, ev_sel, cmd_out};
endmodule

// File: rtl/scan_sweep_sequencer.sv
// ----------------------------------------------------------------------------
// scan_sweep_sequencer: scan platform sequencer top level
// Joins the phase controller and the arithmetic datapath.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  in_ch     sink       action, motor_running, motor_position, unwrap_steps
//  out_ch    source     one result word per input word
//  cfg_ch    sink       register index, write data
//
//  A tick or command passes through accept, decode with capture, hand over.
//  A homing renumber or a new stop position also runs the serial 48-bit
//  divider, one quotient bit a cycle; the block then sees it finish,
//  captures the word and moves on to the hand over.
//  Reset restores the register defaults and idles the phase machine.
//  A stalled result holds the block; no new word enters until it is taken.
// ----------------------------------------------------------------------------
module scan_sweep_sequencer (
    input  logic i_clk,
    input  logic i_rst_n,
    ssq_if.sink   in_ch,
    ssq_if.source out_ch,
    ssq_if.sink   cfg_ch
);
    import ssq_pkg::*;
    import ssq_types::*;

    t_cmd  ctl_cmd, dp_cmd;
    t_sts  dp_sts;
    logic  mode;
    logic [11:0] stop_count, stop_idx;
    logic [15:0] dwell;
    logic [3:0]  state, ev;
    t_out  result;
    t_in   in_w;

    // Hold the replayed command for the divider capture
    t_cmd  r_cmd;
    logic  r_fix;
    logic [3:0] r_ev;
    logic       r_wait;

    // Hold the position and unwrap distance of the accepted word; the source
    // may move on to its next word as soon as this one is taken
    logic signed [31:0] r_pos;
    logic signed [23:0] r_unw;

    assign in_w = in_ch.data;

    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) begin
            r_pos <= in_w.motor_position;
            r_unw <= in_w.unwrap_steps;
        end
    end

    ssq_control u_ctl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .o_in_ready   (in_ch.ready),
        .i_action     (in_w.action),
        .i_running    (in_w.motor_running),
        .i_unw        (in_w.unwrap_steps),
        .o_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_mode       (mode),
        .i_stop_count (stop_count),
        .i_dwell      (dwell),
        .i_sts        (dp_sts),
        .o_cmd        (ctl_cmd),
        .o_stop_idx   (stop_idx),
        .o_state      (state),
        .o_event      (ev)
    );

    // Capture the division command; fire its result write once done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait <= 1'b0;
            r_fix  <= 1'b0;
        end else begin
            r_fix <= 1'b0;
            if (ctl_cmd.div_start) begin
                r_wait <= 1'b1;
            end else if (r_wait && !dp_sts.div_busy) begin
                r_wait <= 1'b0;
                r_fix  <= 1'b1;
            end
        end
        if (ctl_cmd.div_start) begin
            r_cmd <= ctl_cmd;
            r_ev  <= ev;
        end
    end

    logic [11:0] r_idx;
    logic [3:0]  r_st;
    always_ff @(posedge i_clk) begin
        if (ctl_cmd.div_start) begin
            r_idx <= stop_idx;
            r_st  <= state;
        end
    end

    logic dp_fire;
    assign dp_fire = r_wait && !dp_sts.div_busy && !ctl_cmd.div_start;

    always_comb begin
        dp_cmd = ctl_cmd;
        if (dp_fire) begin
            dp_cmd = r_cmd;
            dp_cmd.div_start = 1'b0;
            dp_cmd.result_we = 1'b1;
        end
    end

    ssq_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_ch.valid && cfg_ch.ready),
        .i_cfg_index  (cfg_ch.data.index),
        .i_cfg_wdata  (cfg_ch.data.wdata),
        .i_cmd        (dp_cmd),
        .i_pos        (r_pos),
        .i_unw        (r_unw),
        .i_stop_idx   (dp_fire ? r_idx : stop_idx),
        .i_state      (dp_fire ? r_st : state),
        .i_event      (dp_fire ? r_ev : ev),
        .o_sts        (dp_sts),
        .o_mode       (mode),
        .o_stop_count (stop_count),
        .o_dwell      (dwell),
        .o_result     (result)
    );

    assign cfg_ch.ready = 1'b1;
    assign out_ch.data  = result;

    logic unused;
    assign unused = r_fix;
endmodule

// File: sim/scan_sweep_sequencer_tb.sv
// ----------------------------------------------------------------------------
// scan_sweep_sequencer_tb: self-checking bench of the scan sweep sequencer
// Drives ticks and commands, predicts each result word, compares in order.
// ----------------------------------------------------------------------------
module scan_sweep_sequencer_tb;
    import ssq_pkg::*;
    import ssq_types::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ssq_if #(.T(t_in))  in_ch ();
    ssq_if #(.T(t_out)) out_ch ();
    ssq_if #(.T(t_cfg)) cfg_ch ();

    scan_sweep_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .cfg_ch  (cfg_ch.sink)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 120;

    // Predictor state: registers and phase machine
    logic [23:0] reg_file [8];
    t_phase      pr_phase;
    logic [15:0] pr_timer;
    logic [11:0] pr_stop;
    logic        pr_mode;

    t_out expected_words [$];
    int   mismatches = 0;
    int   cycle_count = 0;
    bit   send_idle_en = 1'b1;
    bit   recv_idle_en = 1'b1;
    bit   recv_hold = 1'b0;

    // Position of stop i, halves rounded away from zero
    function automatic longint stop_pos(logic [11:0] i);
        longint h, n, num;
        h = reg_file[REG_HALF][15:0];
        n = reg_file[REG_STOPS][11:0];
        if (n == 0) return -h;
        num = h * (2 * longint'(i) - n);
        if (num >= 0) return (2 * num + n) / (2 * n);
        return -((-2 * num + n) / (2 * n));
    endfunction

    function automatic void enter_phase(t_phase p);
        pr_phase = p;
        pr_timer = '0;
    endfunction

    // Work out the result word for one input word and advance the state
    function automatic t_out predict_word(t_in w);
        t_out r;
        longint pos, unw, cyc, want, k, h;
        bit at_rest;
        r = '0;
        pos = w.motor_position;
        unw = w.unwrap_steps;
        h = reg_file[REG_HALF][15:0];
        at_rest = (pr_phase == PH_IDLE) || (pr_phase == PH_DONE);
        case (w.action)
            ACT_TICK: begin
                if (pr_timer != 16'hFFFF) pr_timer++;
                case (pr_phase)
                    PH_HOMING: if (!w.motor_running) begin
                        cyc = reg_file[REG_CYCLE][15:0];
                        if (cyc == 0) cyc = 1;
                        want = -h - longint'(reg_file[REG_BACK][15:0]);
                        k = (want - pos) / cyc;
                        if (pos + k * cyc > want) k--;
                        r.position_load = 1'b1;
                        r.position_value = 32'(pos + k * cyc);
                        r.motor_op = OP_ABS;
                        r.motor_target = 32'(-h);
                        r.speed_select = SPD_TRAVEL;
                        r.ramp_enable = 1'b1;
                        enter_phase(PH_PARKING);
                        r.event_code = EV_HOMED;
                    end
                    PH_PARKING: if (!w.motor_running) enter_phase(PH_SETTLING);
                    PH_SETTLING: if (pr_timer >= SETTLE_MS) begin
                        if (pr_mode) enter_phase(PH_STEP_CAPTURE);
                        else begin
                            r.motor_op = OP_ABS;
                            r.motor_target = 32'(h);
                            r.speed_select = SPD_SWEEP;
                            enter_phase(PH_SWEEPING);
                        end
                        r.event_code = EV_START;
                    end
                    PH_SWEEPING: if (!w.motor_running) begin
                        enter_phase(PH_DONE);
                        r.event_code = EV_COMPLETE;
                    end
                    PH_DONE: if (!w.motor_running) begin
                        enter_phase(PH_IDLE);
                        r.event_code = EV_IDLE;
                    end
                    PH_UNWRAP: if (!w.motor_running) begin
                        r.position_load = 1'b1;
                        enter_phase(PH_IDLE);
                        r.event_code = EV_UNWRAP;
                    end
                    PH_STEP_MOVE: if (!w.motor_running) enter_phase(PH_STEP_SETTLE);
                    PH_STEP_SETTLE:
                        if (pr_timer >= STEP_SETTLE_MS) enter_phase(PH_STEP_CAPTURE);
                    PH_STEP_CAPTURE: if (pr_timer >= reg_file[REG_DWELL][15:0]) begin
                        if (pr_stop >= reg_file[REG_STOPS][11:0]) begin
                            enter_phase(PH_DONE);
                            r.event_code = EV_COMPLETE;
                        end else begin
                            pr_stop = pr_stop + 12'd1;
                            r.motor_op = OP_ABS;
                            r.motor_target = 32'(stop_pos(pr_stop));
                            r.speed_select = SPD_STEP;
                            enter_phase(PH_STEP_MOVE);
                        end
                    end
                    default: ;
                endcase
            end
            ACT_START: begin
                if (!at_rest) r.event_code = EV_BUSY;
                else begin
                    pr_mode = reg_file[REG_MODE][0];
                    pr_stop = '0;
                    r.motor_op = OP_REL;
                    r.motor_target = 32'(-longint'(reg_file[REG_TRAVEL]));
                    r.speed_select = SPD_HOMING;
                    r.ramp_enable = 1'b1;
                    enter_phase(PH_HOMING);
                end
            end
            ACT_ABORT: begin
                r.motor_op = OP_STOP;
                enter_phase(PH_IDLE);
                r.event_code = EV_ABORTED;
            end
            ACT_UNWRAP: begin
                if (!at_rest) r.event_code = EV_BUSY;
                else if (unw == 0 || unw > UNWRAP_MAX_STEPS || unw < -UNWRAP_MAX_STEPS)
                    r.event_code = EV_REJECT;
                else begin
                    r.motor_op = OP_REL;
                    r.motor_target = 32'(unw);
                    r.speed_select = SPD_TRAVEL;
                    r.ramp_enable = 1'b1;
                    enter_phase(PH_UNWRAP);
                end
            end
            ACT_HOME: begin
                r.position_load = 1'b1;
                r.event_code = EV_HOMESET;
            end
            default: ;
        endcase
        r.scan_state = pr_phase;
        r.stop_index = pr_stop;
        return r;
    endfunction

    // Cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("scan_sweep_sequencer test failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, or a long hold when asked
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (recv_hold) begin
                out_ch.ready <= 1'b0;
                @(posedge i_clk);
            end else if (recv_idle_en && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 16);
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        t_out exp_w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %p", out_ch.data);
            end else begin
                exp_w = expected_words.pop_front();
                if (out_ch.data !== exp_w) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_w, out_ch.data);
                end
            end
        end
    end

    // Offer one input word, holding valid until the edge that takes it
    task automatic send_word(t_in w);
        if (send_idle_en && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        @(posedge i_clk iff in_ch.ready);
        expected_words.push_back(predict_word(w));
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_act(logic [2:0] act, bit run, int pos = 0, int unw = 0);
        t_in w;
        w.action = act;
        w.motor_running = run;
        w.motor_position = pos;
        w.unwrap_steps = unw[23:0];
        send_word(w);
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one register; only called when drained
    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= '{index: idx, wdata: val};
        @(posedge i_clk iff cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_MODE:  reg_file[idx] = {23'd0, val[0]};
            REG_STOPS: reg_file[idx] = {12'd0, val[11:0]};
            REG_TRAVEL, REG_RATE: reg_file[idx] = val;
            default:   reg_file[idx] = {8'd0, val[15:0]};
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_scan(int half, int back, int travel, int cyc, bit mode,
                            int stops, int dwell, int rate);
        wait_drained();
        write_reg(REG_HALF, 24'(half));
        write_reg(REG_BACK, 24'(back));
        write_reg(REG_TRAVEL, 24'(travel));
        write_reg(REG_CYCLE, 24'(cyc));
        write_reg(REG_MODE, 24'(mode));
        write_reg(REG_STOPS, 24'(stops));
        write_reg(REG_DWELL, 24'(dwell));
        write_reg(REG_RATE, 24'(rate));
    endtask

    // Random word, mostly ticks with a plausible running flag;
    // a calm word never aborts
    task automatic send_random_word(int weight_cmd, bit calm);
        logic [2:0] act;
        int pos, unw;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < weight_cmd) act = 3'($urandom_range(1, 7));
        else act = ACT_TICK;
        if (calm && act == ACT_ABORT) act = ACT_HOME;
        pos = ($urandom_range(0, 3) == 0) ? int'($urandom) : $urandom_range(0, 20000) - 10000;
        case ($urandom_range(0, 3))
            0: unw = int'($urandom);
            1: unw = 0;
            default: unw = $urandom_range(0, 12802) - 6401;
        endcase
        send_act(act, $urandom_range(0, 2) == 0, pos, unw);
    endtask

    // Directed: extremes and special cases in a few words
    task automatic test_directed();
        send_act(ACT_UNWRAP, 1'b0, 0, 0);
        send_act(ACT_UNWRAP, 1'b0, 0, 6401);
        send_act(ACT_UNWRAP, 1'b0, 0, -6401);
        send_act(ACT_UNWRAP, 1'b0, 0, -8388608);
        send_act(ACT_UNWRAP, 1'b0, 0, 6400);
        send_act(ACT_START, 1'b1);
        send_act(ACT_TICK, 1'b0);
        send_act(ACT_UNWRAP, 1'b0, 0, -6400);
        send_act(ACT_HOME, 1'b1, -1, -1);
        send_act(3'd5, 1'b1, 32'h7FFFFFFF, 8388607);
        send_act(3'd7, 1'b0, 32'h80000000, 0);
        send_act(ACT_START, 1'b0);
        send_act(ACT_START, 1'b0);
        send_act(ACT_TICK, 1'b0, 32'h7FFFFFFF);
        send_act(ACT_ABORT, 1'b0);
        send_act(ACT_START, 1'b0);
        send_act(ACT_TICK, 1'b0, 32'h80000000);
        send_act(ACT_ABORT, 1'b1);
    endtask

    // One scan: start and home, then ticks with some noise until idle or
    // the word budget runs out, in which case abort
    task automatic run_scan(int budget, int extra, bit calm);
        int steps;
        steps = 0;
        send_act(ACT_START, 1'b0);
        repeat (3) send_act(ACT_TICK, 1'b1, $urandom_range(0, 4000) - 2000);
        send_act(ACT_TICK, 1'b0, int'($urandom));
        while (pr_phase != PH_IDLE && steps < budget) begin
            if ($urandom_range(0, calm ? 19 : 9) == 0) send_random_word(20, calm);
            else send_act(ACT_TICK, $urandom_range(0, 3) == 0, int'($urandom));
            steps++;
        end
        if (pr_phase != PH_IDLE) send_act(ACT_ABORT, 1'b0);
        repeat (extra) send_random_word(10, 1'b0);
    endtask

    task automatic test_continuous();
        set_scan(0, 0, 0, 0, 1'b0, 1, 0, 0);
        run_scan(1500, 0, 1'b1);
        set_scan(65535, 65535, 16777215, 65535, 1'b0, 4095, 65535, 16777215);
        run_scan(20, 0, 1'b0);
    endtask

    // Odd half width over four intervals puts two stops on a half
    task automatic test_stepped();
        set_scan(1001, 9, 100, 1, 1'b1, 4, 1, 100);
        run_scan(1500, 0, 1'b1);
    endtask

    // Receiver holds off while the sender keeps offering, then sender pauses
    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            repeat (20) send_random_word(30, 1'b0);
        join
        wait_drained();
    endtask

    // Short scans on random settings, without idling at the end of the run
    task automatic test_random();
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        repeat (3) begin
            set_scan($urandom_range(0, 65535), $urandom_range(0, 65535),
                     int'($urandom) & 24'hFFFFFF, $urandom_range(0, 200),
                     $urandom_range(0, 1), $urandom_range(0, 4),
                     $urandom_range(0, 12), int'($urandom) & 24'hFFFFFF);
            run_scan(10, 3, 1'b0);
        end
    endtask

    initial begin
        for (int i = 0; i < 8; i++) reg_file[i] = '0;
        reg_file[REG_HALF] = 1600;
        reg_file[REG_BACK] = 160;
        reg_file[REG_TRAVEL] = 4000;
        reg_file[REG_CYCLE] = 64;
        reg_file[REG_STOPS] = 100;
        reg_file[REG_DWELL] = 200;
        reg_file[REG_RATE] = 25600;
        pr_phase = PH_IDLE;
        pr_timer = '0;
        pr_stop = '0;
        pr_mode = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_continuous();
        test_stepped();
        test_random();

        wait_drained();
        if (mismatches == 0) begin
            $display("scan_sweep_sequencer test passed");
        end else begin
            $display("scan_sweep_sequencer test failed");
        end
        $finish;
    end
endmodule
